### hdl/udrb_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the uart dual ring buffer
// depends on nothing; used by udrb_queue and uart_dual_ring_buffer_unit

package udrb_pkg;

    localparam int DEF_RX_DEPTH = 64;
    localparam int DEF_TX_DEPTH = 64;

    // stored entry: pair flag on top of the data byte
    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = BYTE_W + 1;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic push;
        logic push_pair;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic room2;
        logic empty_next;
    } q_stat_t;

endpackage

### hdl/uart_dual_ring_buffer_unit.sv
`timescale 1ns / 1ps
// top level: input register, receive and transmit queues, result register
// depends on udrb_pkg, udrb_queue, udrb_ram
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | in_valid/in_ready  | operation, data_byte, rx_ready, tx_ready
//  output   | out_valid/out_ready| status, read_byte, line_byte, line_byte_valid,
//           |                    | rx_overrun, tx_irq_enable, tx_empty
//
// one transaction per cycle while out_ready is high; input and result are registered
// the rate is set by the queue ram read port, whose address tracks the next head
// rst_n clears both queues and the interrupt enable at once; no clearing pass
// a stalled output holds its result and the input register, then in_ready drops
// a newline takes two queue slots but one ram write

module uart_dual_ring_buffer_unit #(
    parameter int RX_DEPTH = udrb_pkg::DEF_RX_DEPTH,
    parameter int TX_DEPTH = udrb_pkg::DEF_TX_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] data_byte,
    input  logic       rx_ready,
    input  logic       tx_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] read_byte,
    output logic [7:0] line_byte,
    output logic       line_byte_valid,
    output logic       rx_overrun,
    output logic       tx_empty,
    output logic       tx_irq_enable
);

    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] data_reg;
    logic       rxr_reg, txr_reg;
    logic       fire;

    logic       out_valid_reg;
    logic [1:0] status_reg, status_next;
    logic [7:0] read_byte_reg, read_byte_next;
    logic [7:0] line_byte_reg, line_byte_next;
    logic       line_valid_reg, line_valid_next;
    logic       overrun_reg, overrun_next;
    logic       tx_empty_reg;
    logic       tx_irq_reg, tx_irq_next;

    udrb_pkg::q_ctrl_t rx_ctrl, tx_ctrl;
    udrb_pkg::q_stat_t rx_stat, tx_stat;
    logic [7:0]        rx_head, tx_head;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        rx_ctrl         = '0;
        tx_ctrl         = '0;
        status_next     = udrb_pkg::ST_OK;
        read_byte_next  = '0;
        line_byte_next  = '0;
        line_valid_next = 1'b0;
        overrun_next    = 1'b0;
        tx_irq_next     = tx_irq_reg;
        case (op_reg)
            udrb_pkg::OP_WRITE:
            begin
                if ((data_reg == udrb_pkg::CH_LF) ? tx_stat.room2 : !tx_stat.full)
                begin
                    tx_ctrl.push      = fire;
                    tx_ctrl.push_pair = (data_reg == udrb_pkg::CH_LF);
                    tx_irq_next       = 1'b1;
                end
                else
                begin
                    status_next = udrb_pkg::ST_BUSY;
                end
            end
            udrb_pkg::OP_READ:
            begin
                if (rx_stat.empty)
                begin
                    status_next = udrb_pkg::ST_EMPTY;
                end
                else
                begin
                    rx_ctrl.pop    = fire;
                    read_byte_next = rx_head;
                end
            end
            udrb_pkg::OP_SERVICE:
            begin
                if (rxr_reg)
                begin
                    if (rx_stat.full)
                    begin
                        overrun_next = 1'b1;
                    end
                    else
                    begin
                        rx_ctrl.push = fire;
                    end
                end
                if (txr_reg)
                begin
                    if (tx_stat.empty)
                    begin
                        tx_irq_next = 1'b0;
                    end
                    else
                    begin
                        tx_ctrl.pop     = fire;
                        line_byte_next  = tx_head;
                        line_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    udrb_queue #(
        .DEPTH (RX_DEPTH)
    ) u_rx_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rx_ctrl),
        .push_data (data_reg),
        .stat      (rx_stat),
        .head_byte (rx_head)
    );

    udrb_queue #(
        .DEPTH (TX_DEPTH)
    ) u_tx_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tx_ctrl),
        .push_data (data_reg),
        .stat      (tx_stat),
        .head_byte (tx_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tx_irq_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                tx_irq_reg    <= tx_irq_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= operation;
            data_reg <= data_byte;
            rxr_reg  <= rx_ready;
            txr_reg  <= tx_ready;
        end
        if (fire)
        begin
            status_reg     <= status_next;
            read_byte_reg  <= read_byte_next;
            line_byte_reg  <= line_byte_next;
            line_valid_reg <= line_valid_next;
            overrun_reg    <= overrun_next;
            tx_empty_reg   <= tx_stat.empty_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign read_byte       = read_byte_reg;
    assign line_byte       = line_byte_reg;
    assign line_byte_valid = line_valid_reg;
    assign rx_overrun      = overrun_reg;
    assign tx_empty        = tx_empty_reg;
    assign tx_irq_enable   = tx_irq_reg;

    // a result only appears after the input register held a transaction
    a_result_from_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg)
    ) else $error("result appeared without a held transaction");

    // an accepted cpu write leaves the transmit queue non-empty with the interrupt on
    a_write_fills_tx: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && (op_reg == udrb_pkg::OP_WRITE) && (status_next == udrb_pkg::ST_OK))
        |=> (!tx_empty_reg && tx_irq_reg && !tx_stat.empty)
    ) else $error("cpu write did not queue a byte");

    // a byte sent to the line never comes with a cpu read byte or an error status
    a_line_byte_alone: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_valid_reg)
        |-> ((status_reg == udrb_pkg::ST_OK) && (read_byte_reg == 8'd0))
    ) else $error("line byte mixed with another result");

endmodule

### hdl/udrb_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// write-first on an address collision; no package dependency

module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/udrb_queue.sv
`timescale 1ns / 1ps
// byte ring buffer with pointers modulo twice the depth, one ram entry per push
// depends on udrb_pkg and udrb_ram

module udrb_queue #(
    parameter int DEPTH = udrb_pkg::DEF_TX_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  udrb_pkg::q_ctrl_t          ctrl,
    input  logic [udrb_pkg::BYTE_W-1:0] push_data,
    output udrb_pkg::q_stat_t          stat,
    output logic [udrb_pkg::BYTE_W-1:0] head_byte
);

    localparam int AW   = $clog2(DEPTH);
    localparam int PW   = $clog2(2 * DEPTH);
    localparam int OW   = PW + 1;
    localparam int SPAN = 2 * DEPTH;

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          second_reg, second_next;
    logic [udrb_pkg::BYTE_W-1:0] hold_reg;
    logic [OW-1:0] occ_raw, occ;
    logic [udrb_pkg::ENTRY_W-1:0] ram_q;
    logic [udrb_pkg::ENTRY_W-1:0] ram_wdata;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(SPAN - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        if (p >= PW'(DEPTH))
        begin
            s = p - PW'(DEPTH);
        end
        else
        begin
            s = p;
        end
        return s[AW-1:0];
    endfunction

    always_comb
    begin
        occ_raw = OW'(wr_ptr_reg) + OW'(SPAN) - OW'(rd_ptr_reg);
        if (occ_raw >= OW'(SPAN))
        begin
            occ = occ_raw - OW'(SPAN);
        end
        else
        begin
            occ = occ_raw;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (ctrl.push)
        begin
            if (ctrl.push_pair)
            begin
                wr_ptr_next = ptr_inc(ptr_inc(wr_ptr_reg));
            end
            else
            begin
                wr_ptr_next = ptr_inc(wr_ptr_reg);
            end
        end
        rd_ptr_next = ctrl.pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    end

    // a pair entry pops as carriage return, then as its own byte
    always_comb
    begin
        second_next = second_reg;
        if (second_reg)
        begin
            head_byte = hold_reg;
        end
        else if (ram_q[udrb_pkg::BYTE_W])
        begin
            head_byte = udrb_pkg::CH_CR;
        end
        else
        begin
            head_byte = ram_q[udrb_pkg::BYTE_W-1:0];
        end
        if (ctrl.pop)
        begin
            second_next = !second_reg && ram_q[udrb_pkg::BYTE_W];
        end
    end

    assign stat.empty      = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full       = (occ == OW'(DEPTH));
    assign stat.room2      = (occ <= OW'(DEPTH - 2));
    assign stat.empty_next = (wr_ptr_next == rd_ptr_next);

    assign ram_wdata = {ctrl.push_pair, push_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pop && !second_reg)
        begin
            hold_reg <= ram_q[udrb_pkg::BYTE_W-1:0];
        end
    end

    // read address follows the next head so the data is ready in the next cycle
    udrb_ram #(
        .WIDTH (udrb_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (ptr_slot(wr_ptr_reg)),
        .wdata (ram_wdata),
        .raddr (ptr_slot(rd_ptr_next)),
        .rdata (ram_q)
    );

endmodule
